// File: rtl/core/afb_pkg.sv
// ----------------------------------------------------------------------------
// afb_pkg
// Request and result types and the fixed bytes of the API frame layout.
// ----------------------------------------------------------------------------
package afb_pkg;

	// request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_CONT  = 2'd1;
	localparam logic [1:0] REQ_CMD   = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// parameter selector codes
	localparam logic [1:0] PSEL_04    = 2'd0;
	localparam logic [1:0] PSEL_05    = 2'd1;
	localparam logic [1:0] PSEL_NONE  = 2'd2;
	localparam logic [1:0] PSEL_SPARE = 2'd3;

	localparam logic [7:0] MAX_PAYLOAD = 8'd255;

	// frame bytes
	localparam logic [7:0] SOF_BYTE      = 8'h7E;
	localparam logic [7:0] TYPE_TX       = 8'h10;
	localparam logic [7:0] TYPE_REMOTE   = 8'h17;
	localparam logic [7:0] NET_HI_BYTE   = 8'hFF;
	localparam logic [7:0] NET_LO_BYTE   = 8'hFE;
	localparam logic [7:0] CMD_OPTIONS   = 8'h02;
	localparam logic [7:0] PARAM_04      = 8'h04;
	localparam logic [7:0] PARAM_05      = 8'h05;
	localparam logic [7:0] CSUM_BASE     = 8'hFF;
	localparam logic [8:0] TX_LEN_BASE   = 9'd14;
	localparam logic [8:0] CMD_LEN_PARAM = 9'h010;
	localparam logic [8:0] CMD_LEN_NONE  = 9'h00F;
	localparam logic [7:0] FRAME_ID_RST  = 8'h01;

	// byte positions inside a header
	localparam int unsigned POS_W = 5;
	localparam logic [POS_W-1:0] POS_SOF    = 5'd0;
	localparam logic [POS_W-1:0] POS_LEN_HI = 5'd1;
	localparam logic [POS_W-1:0] POS_LEN_LO = 5'd2;
	localparam logic [POS_W-1:0] POS_TYPE   = 5'd3;
	localparam logic [POS_W-1:0] POS_FID    = 5'd4;
	localparam logic [POS_W-1:0] POS_ADDR0  = 5'd5;
	localparam logic [POS_W-1:0] POS_ADDR7  = 5'd12;
	localparam logic [POS_W-1:0] POS_NET_HI = 5'd13;
	localparam logic [POS_W-1:0] POS_NET_LO = 5'd14;
	localparam logic [POS_W-1:0] POS_B15    = 5'd15;
	localparam logic [POS_W-1:0] POS_B16    = 5'd16;
	localparam logic [POS_W-1:0] POS_B17    = 5'd17;
	localparam logic [POS_W-1:0] POS_B18    = 5'd18;
	localparam logic [POS_W-1:0] POS_B19    = 5'd19;

	// register addresses
	localparam logic [0:0] REG_FRAME_ID = 1'b0;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] dest_addr;
		logic [7:0]  payload_len;
		logic [7:0]  data_byte;
		logic [15:0] command_word;
		logic [1:0]  param_sel;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       status;
		logic       last;
	} rsp_t;

endpackage

// File: rtl/core/api_frame_builder.sv
// ----------------------------------------------------------------------------
// api_frame_builder
// Serializes transmit and remote-command API frames into a checksummed
// byte stream, one byte per result.
// ----------------------------------------------------------------------------
//
//  channel  | signals                            | dir | content
//  ---------+------------------------------------+-----+------------------------
//  request  | req_valid, req_ready, req_data     | in  | afb_pkg::req_t
//  result   | rsp_valid, rsp_ready, rsp_data     | out | afb_pkg::rsp_t, one byte
//  config   | psel penable pwrite paddr pwdata   | in  | frame_id at address 0
//           | prdata pready                      | out |
//
// A request is held in the item register and, unless the result stalls,
// one frame byte per cycle goes to the result register. A request has 1
// or 2 bytes for a continuation, up to 19 for a transmit start and 19 or
// 20 for a remote command. The next request is taken on the cycle its
// predecessor's last byte moves out. A stalled result holds both registers.
// Reset clears the frame state and sets frame_id to 1.
module api_frame_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  afb_pkg::req_t      req_data,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output afb_pkg::rsp_t      rsp_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	afb_pkg::req_t                 item_q;
	logic                          item_vld_q;
	logic [afb_pkg::POS_W-1:0]     pos_q;
	logic [7:0]                    frame_id_q;
	logic [7:0]                    running_sum_q;
	logic [7:0]                    bytes_left_q;
	logic                          frame_open_q;
	logic                          rsp_vld_q;
	afb_pkg::rsp_t                 rsp_q;

	logic                          adv;
	afb_pkg::rsp_t                 byte_d;
	logic                          is_data;
	logic [7:0]                    plen_sat;
	logic                          has_param;
	logic [8:0]                    frame_len;
	logic [2:0]                    lane;
	logic [7:0]                    csum;
	logic [7:0]                    sum_base;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == afb_pkg::REG_FRAME_ID) ? {24'd0, frame_id_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q <= afb_pkg::FRAME_ID_RST;
		end else if (psel && penable && pwrite && paddr[2] == afb_pkg::REG_FRAME_ID) begin
			frame_id_q <= pwdata[7:0];
		end
	end

	assign adv       = item_vld_q && (!rsp_vld_q || rsp_ready);
	assign req_ready = !item_vld_q || (adv && byte_d.last);
	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

	assign plen_sat  = (item_q.payload_len > afb_pkg::MAX_PAYLOAD) ?
		afb_pkg::MAX_PAYLOAD : item_q.payload_len;
	assign has_param = (item_q.param_sel == afb_pkg::PSEL_04) ||
		(item_q.param_sel == afb_pkg::PSEL_05);
	assign frame_len = (item_q.req_type == afb_pkg::REQ_START) ?
		({1'b0, plen_sat} + afb_pkg::TX_LEN_BASE) :
		(has_param ? afb_pkg::CMD_LEN_PARAM : afb_pkg::CMD_LEN_NONE);
	// destination goes out most significant byte first
	assign lane      = 3'(afb_pkg::POS_ADDR7 - pos_q);
	assign csum      = afb_pkg::CSUM_BASE - running_sum_q;
	assign sum_base  = (pos_q == afb_pkg::POS_TYPE &&
		item_q.req_type != afb_pkg::REQ_CONT) ? 8'd0 : running_sum_q;

	// byte selection for the current position
	always_comb begin
		byte_d  = '0;
		is_data = 1'b0;
		if (item_q.req_type == afb_pkg::REQ_CONT) begin
			if (!frame_open_q) begin
				byte_d.status = 1'b1;
				byte_d.last   = 1'b1;
			end else if (pos_q == afb_pkg::POS_SOF) begin
				byte_d.out_byte = item_q.data_byte;
				byte_d.last     = (bytes_left_q == 8'd1) ? 1'b0 : 1'b1;
				is_data         = 1'b1;
			end else begin
				byte_d.out_byte  = csum;
				byte_d.frame_end = 1'b1;
				byte_d.last      = 1'b1;
			end
		end else if (pos_q <= afb_pkg::POS_NET_LO) begin
			is_data = (pos_q >= afb_pkg::POS_TYPE);
			if (pos_q == afb_pkg::POS_SOF) begin
				byte_d.out_byte = afb_pkg::SOF_BYTE;
			end else if (pos_q == afb_pkg::POS_LEN_HI) begin
				byte_d.out_byte = {7'd0, frame_len[8]};
			end else if (pos_q == afb_pkg::POS_LEN_LO) begin
				byte_d.out_byte = frame_len[7:0];
			end else if (pos_q == afb_pkg::POS_TYPE) begin
				byte_d.out_byte = (item_q.req_type == afb_pkg::REQ_START) ?
					afb_pkg::TYPE_TX : afb_pkg::TYPE_REMOTE;
			end else if (pos_q == afb_pkg::POS_FID) begin
				byte_d.out_byte = frame_id_q;
			end else if (pos_q <= afb_pkg::POS_ADDR7) begin
				byte_d.out_byte = item_q.dest_addr[{lane, 3'b000} +: 8];
			end else if (pos_q == afb_pkg::POS_NET_HI) begin
				byte_d.out_byte = afb_pkg::NET_HI_BYTE;
			end else begin
				byte_d.out_byte = afb_pkg::NET_LO_BYTE;
			end
		end else if (item_q.req_type == afb_pkg::REQ_START) begin
			priority if (pos_q == afb_pkg::POS_B15 || pos_q == afb_pkg::POS_B16) begin
				is_data = 1'b1;
			end else if (pos_q == afb_pkg::POS_B17 && plen_sat != 8'd0) begin
				byte_d.out_byte = item_q.data_byte;
				byte_d.last     = (plen_sat == 8'd1) ? 1'b0 : 1'b1;
				is_data         = 1'b1;
			end else begin
				byte_d.out_byte  = csum;
				byte_d.frame_end = 1'b1;
				byte_d.last      = 1'b1;
			end
		end else begin
			priority if (pos_q == afb_pkg::POS_B15) begin
				byte_d.out_byte = afb_pkg::CMD_OPTIONS;
				is_data         = 1'b1;
			end else if (pos_q == afb_pkg::POS_B16) begin
				byte_d.out_byte = item_q.command_word[15:8];
				is_data         = 1'b1;
			end else if (pos_q == afb_pkg::POS_B17) begin
				byte_d.out_byte = item_q.command_word[7:0];
				is_data         = 1'b1;
			end else if (pos_q == afb_pkg::POS_B18 && has_param) begin
				byte_d.out_byte = (item_q.param_sel == afb_pkg::PSEL_04) ?
					afb_pkg::PARAM_04 : afb_pkg::PARAM_05;
				is_data         = 1'b1;
			end else begin
				byte_d.out_byte  = csum;
				byte_d.frame_end = 1'b1;
				byte_d.last      = 1'b1;
			end
		end
	end

	// item register and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
			pos_q      <= '0;
		end else if (req_valid && req_ready) begin
			item_vld_q <= (req_data.req_type != afb_pkg::REQ_NONE);
			pos_q      <= '0;
		end else if (adv) begin
			if (byte_d.last) begin
				item_vld_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req_data;
		end
	end

	// frame state, updated as bytes leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			bytes_left_q  <= '0;
			frame_open_q  <= 1'b0;
		end else if (adv) begin
			if (is_data) begin
				running_sum_q <= sum_base + byte_d.out_byte;
			end
			if (byte_d.last) begin
				unique case (item_q.req_type)
					afb_pkg::REQ_START: begin
						if (plen_sat > 8'd1) begin
							bytes_left_q <= plen_sat - 8'd1;
							frame_open_q <= 1'b1;
						end else begin
							frame_open_q <= 1'b0;
						end
					end
					afb_pkg::REQ_CONT: begin
						if (frame_open_q) begin
							bytes_left_q <= bytes_left_q - 8'd1;
							frame_open_q <= (bytes_left_q != 8'd1);
						end
					end
					afb_pkg::REQ_CMD: begin
						bytes_left_q <= '0;
						frame_open_q <= 1'b0;
					end
					default: begin
						frame_open_q <= frame_open_q;
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= byte_d;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_vld_q |-> pos_q <= afb_pkg::POS_B19)
		else $error("byte position past end of frame");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_q.frame_end |-> rsp_q.last)
		else $error("checksum byte not marked last");

	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> bytes_left_q != 8'd0)
		else $error("open frame with no bytes left");

	a_status_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_q.status |-> rsp_q.last && rsp_q.out_byte == 8'd0 &&
			!rsp_q.frame_end)
		else $error("dropped continuation result malformed");

	a_take_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_vld_q && req_ready |-> adv && byte_d.last)
		else $error("request taken while item still in progress");

endmodule
